FILE: sv/fppt_pkg.sv
// -----------------------------------------------------------------------------
// fppt_pkg: shared types and constants of the FIFO page pool tag store
// Key layout, command codes and the control bundle of the tag store.
// -----------------------------------------------------------------------------
package fppt_pkg;

   localparam int POOL_ENTRIES = 8;
   localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CNT_W        = 7;

   typedef enum logic [1:0] {
      CMD_ACCESS     = 2'd0,
      CMD_INVALIDATE = 2'd1,
      CMD_WRITE      = 2'd2,
      CMD_CLEAR      = 2'd3
   } cmd_type;

   // Page key, namespace flag in the top bit.
   typedef struct packed {
      logic        is_hash;
      logic [15:0] table_id;
      logic [19:0] page;
   } key_type;

   // Control bundle from the sequencer to the tag store.
   typedef struct packed {
      logic             wr_en;
      logic             wr_shift;   // write the entry being read instead of wr_key
      logic [IDX_W-1:0] wr_addr;
      key_type          wr_key;
      logic [IDX_W-1:0] rd_addr;
      key_type          cmp_key;
   } store_ctl_type;

endpackage

FILE: sv/fppt_tag_store.sv
// -----------------------------------------------------------------------------
// fppt_tag_store: key array with one read port and the shared key comparator
// One write and one read address per cycle; match compares the read entry.
// -----------------------------------------------------------------------------
module fppt_tag_store (
   input  logic                   clock,
   input  fppt_pkg::store_ctl_type ctl,
   output fppt_pkg::key_type      rd_key,
   output logic                   match
);
   import fppt_pkg::*;

   key_type keys_ff [POOL_ENTRIES];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         keys_ff[ctl.wr_addr] <= ctl.wr_shift ? rd_key : ctl.wr_key;
      end
   end

   assign rd_key = keys_ff[ctl.rd_addr];
   assign match  = (rd_key == ctl.cmp_key);

endmodule

FILE: sv/fifo_page_pool_tags_top.sv
// -----------------------------------------------------------------------------
// fifo_page_pool_tags_top: tag store of a fully associative FIFO page pool
// Access, invalidate, write-insert and clear on a pool of page keys.
// -----------------------------------------------------------------------------
// One request is handled at a time by a small sequencer around a single key
// comparator and a one-read, one-write key array. A request passes from the
// idle state that accepts it through the scan and the update to a state that
// loads the result register. The scan checks one entry per cycle until a hit
// or until it has passed every held entry. Removing a matched entry moves
// each younger entry down one place and then drops the count; a miss on a
// full pool captures the oldest entry and then pushes it out the same way;
// an append then writes the new key behind the held entries. Clear goes
// from the idle state straight to the result state. req_tready is high only
// while the sequencer is idle; the result sits in an output register, so a
// new request is taken while the previous result still waits for
// rsp_tready, and the sequencer holds in its last state while that register
// is occupied. The key array has no reset; only the fill count is cleared,
// and entries beyond it are never used.
// -----------------------------------------------------------------------------
module fifo_page_pool_tags_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // table_id[15:0], page_index[35:16], zero
   input  logic [2:0]  req_tuser,   // command[1:0], is_hash_page[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // hit[0], evicted[1], evicted_is_hash[2],
                                    // evicted_table[18:3], evicted_page[38:19],
                                    // occupancy[45:39], zero
);
   import fppt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVICT,
      ST_SHIFT,
      ST_APPEND,
      ST_DONE
   } state_type;

   state_type       state_ff, state_in;
   cmd_type         cmd_ff, cmd_in;
   key_type         key_ff, key_in;
   key_type         victim_ff, victim_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            hit_ff, hit_in;
   logic            evict_ff, evict_in;
   logic            append_ff, append_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [47:0]     rsp_data_ff, rsp_data_in;

   store_ctl_type   ctl;
   key_type         rd_key;
   logic            match;
   logic [CNT_W-1:0] idx_next;
   key_type         req_key;

   assign idx_next = idx_ff + CNT_W'(1);

   assign req_key.is_hash  = req_tuser[2];
   assign req_key.table_id = req_tdata[15:0];
   assign req_key.page     = req_tdata[35:16];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   fppt_tag_store u_store (
      .clock  (clock),
      .ctl    (ctl),
      .rd_key (rd_key),
      .match  (match)
   );

   // Drive the tag store. Read at the scan pointer, or one above it while
   // compacting; move that entry down one place, or write the new key on append.
   always_comb begin
      ctl.rd_addr  = (state_ff == ST_SHIFT) ? idx_next[IDX_W-1:0] : idx_ff[IDX_W-1:0];
      ctl.cmp_key  = key_ff;
      ctl.wr_en    = 1'b0;
      ctl.wr_shift = 1'b0;
      ctl.wr_addr  = idx_ff[IDX_W-1:0];
      ctl.wr_key   = key_ff;
      case (state_ff)
         ST_SHIFT: begin
            if (idx_next < count_ff) begin
               ctl.wr_en    = 1'b1;
               ctl.wr_shift = 1'b1;
            end
         end
         ST_APPEND: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = count_ff[IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      victim_in    = victim_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      evict_in     = evict_ff;
      append_in    = append_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Drop the result once the consumer takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = cmd_type'(req_tuser[1:0]);
               key_in    = req_key;
               victim_in = '0;
               idx_in    = '0;
               hit_in    = 1'b0;
               evict_in  = 1'b0;
               append_in = 1'b0;
               if (cmd_type'(req_tuser[1:0]) == CMD_CLEAR) begin
                  count_in = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               // Miss: invalidate leaves the pool alone, the others append.
               if (cmd_ff == CMD_INVALIDATE) begin
                  state_in = ST_DONE;
               end else if (count_ff == CNT_W'(POOL_ENTRIES)) begin
                  idx_in    = '0;
                  append_in = 1'b1;
                  state_in  = ST_EVICT;
               end else begin
                  state_in = ST_APPEND;
               end
            end else if (match) begin
               hit_in = 1'b1;
               if (cmd_ff == CMD_ACCESS) begin
                  state_in = ST_DONE;
               end else begin
                  // Remove the match in place; write-insert appends afterwards.
                  append_in = (cmd_ff == CMD_WRITE);
                  state_in  = ST_SHIFT;
               end
            end else begin
               idx_in = idx_next;
            end
         end
         ST_EVICT: begin
            // Capture the oldest entry before it is overwritten.
            evict_in  = 1'b1;
            victim_in = rd_key;
            state_in  = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (idx_next < count_ff) begin
               idx_in = idx_next;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = append_ff ? ST_APPEND : ST_DONE;
            end
         end
         ST_APPEND: begin
            count_in = count_ff + CNT_W'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, count_ff, victim_ff.page, victim_ff.table_id,
                               victim_ff.is_hash, evict_ff, hit_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         evict_ff     <= 1'b0;
         append_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         evict_ff     <= evict_in;
         append_ff    <= append_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      victim_ff   <= victim_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
